[rtl/lzss_pkg.sv]
// Shared constants for the flag-byte LZSS decompressor.
package lzss_pkg;

    // History window depth and the address width that follows from it.
    localparam int HISTORY_DEPTH = 4096;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    // Field widths fixed by the stream format.
    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int OLEN_W = 24;
    localparam int DIST_W = 13;
    localparam int MLEN_W = 5;
    localparam int TOK_W  = 3;

    // Low nibble of a match word holds the length code.
    localparam logic [3:0] LEN_MASK = 4'hF;

    // Configuration register indexes.
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_OLEN = 1'b1;

    // Compression mode codes.
    localparam logic [MODE_W-1:0] MODE_STORED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX    = 2'd2;

endpackage

[rtl/lzss_flag_byte_decompressor_core.sv]
// Flag-byte LZSS decompressor: one compressed byte per input beat, one output byte per beat.
//
// Each input beat carries one byte of the compressed stream. A flag byte or the low byte of a
// match word is only stored; a literal (or any byte in stored mode 0) is loaded into the output
// register as it is accepted. The high byte of a match word starts a copy of L bytes, L being
// the match length of 2 to 18 (mode + 1 plus the low nibble): the fetch state sets up the
// window address and then the single read port of the history RAM copies one byte per cycle,
// with a bypass for overlapping copies at distance one. Output stalls pause the copy.
// The history RAM needs no clearing after reset; matches must only reach bytes written since
// reset. Every output beat carries is_last, which is set on the byte that completes the
// configured output length; the parser then expects a flag byte again. Writing either
// configuration register starts a new entry and is allowed only while the block is idle; the
// input is stalled during the write. An output length of zero acts as one, and mode 3 acts as
// mode 2.
module lzss_flag_byte_decompressor_core
    import lzss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [OLEN_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_is_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_COPY
    } t_state;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_HIGH
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [MODE_W-1:0]  r_mode;
    logic [OLEN_W-1:0]  r_olen;
    logic [OLEN_W-1:0]  r_remaining;
    logic [HIST_AW-1:0] r_wp;
    logic [BYTE_W-1:0]  r_flags;
    logic [TOK_W-1:0]   r_token;
    logic [BYTE_W-1:0]  r_low;
    logic [DIST_W-1:0]  r_dist;
    logic [MLEN_W-1:0]  r_count;
    logic [HIST_AW-1:0] r_src;
    logic               r_byp;
    logic [BYTE_W-1:0]  r_byp_data;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_is_last;

    logic [MODE_W-1:0]  mode_eff;
    logic               out_free;
    logic               in_acc;
    logic               emit_en;
    logic               emit_last;
    logic [BYTE_W-1:0]  emit_data;
    logic [BYTE_W-1:0]  ram_q;
    logic [BYTE_W-1:0]  copy_byte;
    logic               ram_re;
    logic [HIST_AW-1:0] ram_raddr;
    logic [HIST_AW:0]   src_diff;
    logic [HIST_AW-1:0] src_first;
    logic [HIST_AW-1:0] src_next;
    logic [HIST_AW-1:0] wp_next;
    logic [OLEN_W-1:0]  olen_eff;
    logic [OLEN_W-1:0]  cfg_olen_eff;
    logic [MLEN_W-1:0]  match_len;
    logic [DIST_W-1:0]  match_dist;
    logic               tok_is_lit;
    logic               copy_done;

    assign mode_eff     = (r_mode > MODE_MAX) ? MODE_MAX : r_mode;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall   = !((r_state == S_IDLE) && out_free && !i_cfg_we);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign tok_is_lit   = r_flags[r_token];
    assign emit_last    = (r_remaining == OLEN_W'(1));
    assign olen_eff     = (r_olen == '0) ? OLEN_W'(1) : r_olen;
    assign cfg_olen_eff = (i_cfg_data == '0) ? OLEN_W'(1) : i_cfg_data;
    assign copy_byte    = r_byp ? r_byp_data : ram_q;
    assign copy_done    = (r_count == MLEN_W'(1));

    // The distance is the top 12 bits of the little-endian match word plus one.
    assign match_dist = DIST_W'({i_in_byte, r_low[BYTE_W-1:4]}) + DIST_W'(1);
    assign match_len  = MLEN_W'(r_low & LEN_MASK) + MLEN_W'(mode_eff) + MLEN_W'(1);

    // The match source is the write pointer minus the distance, wrapped into the window.
    assign src_diff  = (HIST_AW+1)'(r_wp) - (HIST_AW+1)'(r_dist);
    assign src_first = src_diff[HIST_AW]
                     ? HIST_AW'(src_diff + (HIST_AW+1)'(HISTORY_DEPTH))
                     : HIST_AW'(src_diff);
    assign src_next  = (r_src == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : r_src + HIST_AW'(1);
    assign wp_next   = (r_wp == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + HIST_AW'(1);

    always_comb begin
        emit_en   = 1'b0;
        emit_data = i_in_byte;
        ram_re    = 1'b0;
        ram_raddr = src_next;
        case (r_state)
            S_IDLE: begin
                if (in_acc && ((mode_eff == MODE_STORED) ||
                               ((r_phase == PH_TOKEN) && tok_is_lit))) begin
                    emit_en = 1'b1;
                end
            end
            S_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = src_first;
            end
            S_COPY: begin
                emit_data = copy_byte;
                if (out_free) begin
                    emit_en = 1'b1;
                    ram_re  = !emit_last && !copy_done;
                end
            end
            default: begin
                emit_en = 1'b0;
            end
        endcase
    end

    lzss_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (emit_en),
        .i_waddr(r_wp),
        .i_wdata(emit_data),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_FLAG;
            r_mode      <= MODE_W'(1);
            r_olen      <= OLEN_W'(1);
            r_remaining <= OLEN_W'(1);
            r_wp        <= '0;
            r_flags     <= '0;
            r_token     <= '0;
            r_count     <= '0;
            r_src       <= '0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= emit_en;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        if (i_cfg_index == CFG_MODE) begin
                            r_mode      <= i_cfg_data[MODE_W-1:0];
                            r_remaining <= olen_eff;
                        end else begin
                            r_olen      <= i_cfg_data;
                            r_remaining <= cfg_olen_eff;
                        end
                        r_phase <= PH_FLAG;
                        r_token <= '0;
                        r_flags <= '0;
                    end else if (in_acc && (mode_eff != MODE_STORED)) begin
                        case (r_phase)
                            PH_FLAG: begin
                                r_flags <= i_in_byte;
                                r_token <= '0;
                                r_phase <= PH_FLAG == PH_FLAG ? PH_TOKEN : PH_TOKEN;
                            end
                            PH_TOKEN: begin
                                if (tok_is_lit) begin
                                    // The last byte of an entry restarts the parser below.
                                    if (!emit_last) begin
                                        r_token <= r_token + TOK_W'(1);
                                        r_phase <= (r_token == '1) ? PH_FLAG : PH_TOKEN;
                                    end
                                end else begin
                                    r_phase <= PH_HIGH;
                                end
                            end
                            PH_HIGH: begin
                                r_count <= match_len;
                                r_state <= S_FETCH;
                            end
                            default: begin
                                r_phase <= PH_FLAG;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_src   <= src_first;
                    r_byp   <= 1'b0;
                    r_state <= S_COPY;
                end
                S_COPY: begin
                    if (out_free) begin
                        if (emit_last) begin
                            r_byp   <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (copy_done) begin
                            r_byp   <= 1'b0;
                            r_token <= r_token + TOK_W'(1);
                            r_phase <= (r_token == '1) ? PH_FLAG : PH_TOKEN;
                            r_state <= S_IDLE;
                        end else begin
                            r_count <= r_count - MLEN_W'(1);
                            r_src   <= src_next;
                            // At distance one the next read hits the byte written now.
                            r_byp   <= (src_next == r_wp);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (emit_en) begin
                r_wp <= wp_next;
                if (emit_last) begin
                    r_remaining <= olen_eff;
                    r_phase     <= PH_FLAG;
                    r_token     <= '0;
                    r_flags     <= '0;
                end else begin
                    r_remaining <= r_remaining - OLEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_out_byte <= emit_data;
            r_is_last  <= emit_last;
            r_byp_data <= emit_data;
        end
        if (in_acc && (r_phase == PH_TOKEN)) begin
            r_low <= i_in_byte;
        end
        if (in_acc && (r_phase == PH_HIGH)) begin
            r_dist <= match_dist;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_last   = r_is_last;

    a_remaining_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining != '0)
        else $error("bytes remaining dropped to zero");

    a_busy_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input accepted while a match copy is running");

    a_copy_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_count != '0))
        else $error("match copy running with an empty byte count");

    a_last_restarts_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_en && emit_last) |=> ((r_phase == PH_FLAG) && (r_token == '0) &&
                                    (r_state == S_IDLE)))
        else $error("entry did not restart after the last byte");

    a_bypass_only_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> (r_state == S_COPY))
        else $error("read bypass set outside a match copy");

endmodule

[rtl/lzss_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
